### rtl/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg
// shared types and constants of the block section indication unit
// ----------------------------------------------------------------------------
package bsi_pkg;

	localparam int BLINK_W  = 12;
	localparam int WINDOW_W = 8;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [BLINK_W-1:0]  BLINK_PERIOD_RST  = BLINK_W'(1000);
	localparam logic [WINDOW_W-1:0] CANCEL_WINDOW_RST = WINDOW_W'(120);

	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_WINDOW = 2'd1;

	typedef logic [1:0] status_t;
	localparam status_t STAT_NONE         = 2'd0;
	localparam status_t STAT_LINE_CLEAR   = 2'd1;
	localparam status_t STAT_TRAIN_MOVING = 2'd2;
	localparam status_t STAT_TRAIN_EXIT   = 2'd3;

	typedef enum logic [2:0] {
		PH_BLINK   = 3'd0,
		PH_CLOSED  = 3'd1,
		PH_CLEAR   = 3'd2,
		PH_ON_LINE = 3'd3,
		PH_EXIT    = 3'd4
	} phase_t;

	// inputs of one machine for one evaluation step
	typedef struct packed {
		logic relay;
		logic clear;
		logic cancel_btn;
		logic push_btn;
		logic coop;
	} mach_in_t;

	// next visible state of one machine
	typedef struct packed {
		logic    lamp;
		status_t status;
		phase_t  phase;
	} mach_out_t;

	// one registered request
	typedef struct packed {
		logic tgt_relay_fb;
		logic tcf_relay_fb;
		logic send_track_clear;
		logic recv_track_clear;
		logic far_cancel_button;
		logic far_push_button;
		logic near_coop_cancel;
		logic near_cancel_button;
		logic near_push_button;
		logic far_coop_cancel;
		logic ms_tick;
		logic sec_tick;
	} item_t;

endpackage

### rtl/bsi_if.sv
// ----------------------------------------------------------------------------
// bsi_in_if / bsi_out_if
// valid/ready channels of the block section indication unit
// ----------------------------------------------------------------------------
interface bsi_in_if;
	logic valid;
	logic ready;
	logic tgt_relay_fb;
	logic tcf_relay_fb;
	logic send_track_clear;
	logic recv_track_clear;
	logic far_cancel_button;
	logic far_push_button;
	logic near_coop_cancel;
	logic near_cancel_button;
	logic near_push_button;
	logic far_coop_cancel;
	logic ms_tick;
	logic sec_tick;

	modport source (output valid, tgt_relay_fb, tcf_relay_fb, send_track_clear,
		recv_track_clear, far_cancel_button, far_push_button, near_coop_cancel,
		near_cancel_button, near_push_button, far_coop_cancel, ms_tick, sec_tick,
		input ready);
	modport sink (input valid, tgt_relay_fb, tcf_relay_fb, send_track_clear,
		recv_track_clear, far_cancel_button, far_push_button, near_coop_cancel,
		near_cancel_button, near_push_button, far_coop_cancel, ms_tick, sec_tick,
		output ready);
endinterface

interface bsi_out_if;
	logic       valid;
	logic       ready;
	logic       send_lamp;
	logic       recv_lamp;
	logic       cancel_lamp;
	logic       coop_pending;
	logic [1:0] send_status;
	logic [1:0] recv_status;
	logic [2:0] send_phase;
	logic [2:0] recv_phase;

	modport source (output valid, send_lamp, recv_lamp, cancel_lamp, coop_pending,
		send_status, recv_status, send_phase, recv_phase, input ready);
	modport sink (input valid, send_lamp, recv_lamp, cancel_lamp, coop_pending,
		send_status, recv_status, send_phase, recv_phase, output ready);
endinterface

### rtl/block_section_indication_fsm_unit.sv
// a request is registered in the input stage when accepted, its result loads into the result register when it steps
// throughput: one request per cycle unless the result channel stalls, the machines step once per request
// a registered input stage and a result register part the two channels
// reset: asynchronous, both machines in the blink phase, counters and lamps
// cleared, cancel window loaded with the reset window of 120 seconds
// ----------------------------------------------------------------------------
// block_section_indication_fsm_unit
// sending and receiving line indication machines with shared cancel window
// ----------------------------------------------------------------------------
module block_section_indication_fsm_unit import bsi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bsi_in_if.sink               sample,
	bsi_out_if.source            indication
);

	logic [BLINK_W-1:0]  blink_period_q;
	logic [WINDOW_W-1:0] cancel_window_q;
	logic [WINDOW_W-1:0] window_q;
	logic [WINDOW_W-1:0] window_dec;
	logic [WINDOW_W-1:0] window_mid;
	logic [WINDOW_W-1:0] window_nxt;

	item_t     item_s1;
	logic      valid_s1;
	logic      adv;
	logic      res_valid_q;
	mach_in_t  send_in;
	mach_in_t  recv_in;
	mach_out_t send_nxt;
	mach_out_t recv_nxt;
	logic      send_req_nxt;
	logic      cancel_lamp_nxt;
	logic      send_reload;
	logic      recv_reload;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q  <= BLINK_PERIOD_RST;
			cancel_window_q <= CANCEL_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BLINK_PERIOD:  blink_period_q  <= cfg_wdata[BLINK_W-1:0];
				CFG_CANCEL_WINDOW: cancel_window_q <= cfg_wdata[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv              = valid_s1 && (!res_valid_q || indication.ready);
	assign sample.ready     = !valid_s1 || adv;
	assign indication.valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample.ready) valid_s1 <= sample.valid;
			if (adv) res_valid_q <= 1'b1;
			else if (indication.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1.tgt_relay_fb       <= sample.tgt_relay_fb;
			item_s1.tcf_relay_fb       <= sample.tcf_relay_fb;
			item_s1.send_track_clear   <= sample.send_track_clear;
			item_s1.recv_track_clear   <= sample.recv_track_clear;
			item_s1.far_cancel_button  <= sample.far_cancel_button;
			item_s1.far_push_button    <= sample.far_push_button;
			item_s1.near_coop_cancel   <= sample.near_coop_cancel;
			item_s1.near_cancel_button <= sample.near_cancel_button;
			item_s1.near_push_button   <= sample.near_push_button;
			item_s1.far_coop_cancel    <= sample.far_coop_cancel;
			item_s1.ms_tick            <= sample.ms_tick;
			item_s1.sec_tick           <= sample.sec_tick;
		end
	end

	// shared cancel window, sending machine reloads first
	assign window_dec = (item_s1.sec_tick && window_q != '0) ? window_q - WINDOW_W'(1)
		: window_q;
	assign window_mid = send_reload ? cancel_window_q : window_dec;
	assign window_nxt = recv_reload ? cancel_window_q : window_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= CANCEL_WINDOW_RST;
		else if (adv) window_q <= window_nxt;
	end

	assign send_in = '{relay: item_s1.tgt_relay_fb, clear: item_s1.send_track_clear,
		cancel_btn: item_s1.far_cancel_button, push_btn: item_s1.far_push_button,
		coop: item_s1.near_coop_cancel};
	assign recv_in = '{relay: item_s1.tcf_relay_fb, clear: item_s1.recv_track_clear,
		cancel_btn: item_s1.near_cancel_button, push_btn: item_s1.near_push_button,
		coop: item_s1.far_coop_cancel};

	bsi_send_fsm u_send (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.mi           (send_in),
		.ms_tick      (item_s1.ms_tick),
		.win_live     (window_dec != '0),
		.blink_period (blink_period_q),
		.nxt          (send_nxt),
		.req_nxt      (send_req_nxt),
		.reload       (send_reload)
	);

	bsi_recv_fsm u_recv (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (adv),
		.mi              (recv_in),
		.ms_tick         (item_s1.ms_tick),
		.win_live        (window_mid != '0),
		.blink_period    (blink_period_q),
		.nxt             (recv_nxt),
		.cancel_lamp_nxt (cancel_lamp_nxt),
		.reload          (recv_reload)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			indication.send_lamp    <= send_nxt.lamp;
			indication.recv_lamp    <= recv_nxt.lamp;
			indication.cancel_lamp  <= cancel_lamp_nxt;
			indication.coop_pending <= send_req_nxt;
			indication.send_status  <= send_nxt.status;
			indication.recv_status  <= recv_nxt.status;
			indication.send_phase   <= send_nxt.phase;
			indication.recv_phase   <= recv_nxt.phase;
		end
	end

`ifndef SYNTHESIS
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a request while stalled");

	a_reload_window: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (send_reload || recv_reload) |=> window_q == $past(cancel_window_q))
		else $error("cancel window not reloaded");

	a_exit_clears_req: assert property (@(posedge clk) disable iff (!arst_n)
		adv && u_send.phase_q == PH_EXIT && send_nxt.phase == PH_BLINK
		|-> !send_req_nxt)
		else $error("sending cancel request kept after exit");

	a_result_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(adv))
		else $error("result shown without a stepped request");
`endif

endmodule

### rtl/bsi_send_fsm.sv
// ----------------------------------------------------------------------------
// bsi_send_fsm
// sending side indication machine with its blink counter and cancel latch
// ----------------------------------------------------------------------------
module bsi_send_fsm import bsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mach_in_t           mi,
	input  logic               ms_tick,
	input  logic               win_live,
	input  logic [BLINK_W-1:0] blink_period,
	output mach_out_t          nxt,
	output logic               req_nxt,
	output logic               reload
);

	phase_t             phase_q;
	phase_t             phase_nxt;
	logic [BLINK_W-1:0] cnt_q;
	logic [BLINK_W-1:0] cnt_dec;
	logic [BLINK_W-1:0] cnt_nxt;
	logic               lamp_q;
	logic               lamp_nxt;
	logic               req_q;
	status_t            status_q;
	status_t            status_nxt;
	logic               req_set;
	logic               coop_go;
	logic               entry;
	logic               moving;
	logic               leaving;

	assign cnt_dec = (ms_tick && cnt_q != '0) ? cnt_q - BLINK_W'(1) : cnt_q;
	assign req_set = req_q | (mi.cancel_btn & mi.push_btn);
	assign coop_go = mi.coop & req_set;
	assign entry   = mi.relay & ~mi.clear;
	assign moving  = mi.relay & mi.clear;
	assign leaving = ~mi.relay & mi.clear;
	assign reload  = ((phase_q == PH_CLEAR) && !entry && coop_go)
		|| ((phase_q == PH_ON_LINE) && moving && coop_go);

	assign nxt = '{lamp: lamp_nxt, status: status_nxt, phase: phase_nxt};

	// next state
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_BLINK: begin
				if (!win_live && !mi.relay) phase_nxt = PH_CLOSED;
			end
			PH_CLOSED: begin
				if (moving) phase_nxt = PH_CLEAR;
			end
			PH_CLEAR: begin
				if (entry) phase_nxt = PH_ON_LINE;
				else if (coop_go) phase_nxt = PH_BLINK;
			end
			PH_ON_LINE: begin
				if (moving) begin
					if (coop_go) phase_nxt = PH_BLINK;
				end else if (leaving) begin
					phase_nxt = PH_EXIT;
				end
			end
			PH_EXIT: begin
				if (leaving) phase_nxt = PH_BLINK;
			end
			default: phase_nxt = phase_q;
		endcase
	end

	// outputs
	always_comb begin
		lamp_nxt   = lamp_q;
		status_nxt = status_q;
		req_nxt    = req_q;
		cnt_nxt    = cnt_dec;
		case (phase_q)
			PH_BLINK: begin
				if (win_live) begin
					if (cnt_dec == '0) begin
						lamp_nxt = ~lamp_q;
						cnt_nxt  = blink_period;
					end
				end else if (!mi.relay) begin
					lamp_nxt = 1'b0;
				end
			end
			PH_CLOSED: begin
				if (moving) begin
					lamp_nxt   = 1'b1;
					status_nxt = STAT_LINE_CLEAR;
				end
			end
			PH_CLEAR: begin
				if (entry) lamp_nxt = 1'b0;
				else req_nxt = req_set & ~coop_go;
			end
			PH_ON_LINE: begin
				if (moving) begin
					if (cnt_dec == '0) begin
						lamp_nxt = ~lamp_q;
						cnt_nxt  = blink_period;
					end
					req_nxt    = req_set & ~coop_go;
					status_nxt = STAT_TRAIN_MOVING;
				end
			end
			PH_EXIT: begin
				if (leaving) begin
					lamp_nxt   = 1'b0;
					req_nxt    = 1'b0;
					status_nxt = STAT_TRAIN_EXIT;
				end
			end
			default: lamp_nxt = lamp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BLINK;
			cnt_q    <= '0;
			lamp_q   <= 1'b0;
			req_q    <= 1'b0;
			status_q <= STAT_NONE;
		end else if (step) begin
			phase_q  <= phase_nxt;
			cnt_q    <= cnt_nxt;
			lamp_q   <= lamp_nxt;
			req_q    <= req_nxt;
			status_q <= status_nxt;
		end
	end

endmodule

### rtl/bsi_recv_fsm.sv
// ----------------------------------------------------------------------------
// bsi_recv_fsm
// receiving side indication machine with blink counter, cancel lamp and latch
// ----------------------------------------------------------------------------
module bsi_recv_fsm import bsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mach_in_t           mi,
	input  logic               ms_tick,
	input  logic               win_live,
	input  logic [BLINK_W-1:0] blink_period,
	output mach_out_t          nxt,
	output logic               cancel_lamp_nxt,
	output logic               reload
);

	phase_t             phase_q;
	phase_t             phase_nxt;
	logic [BLINK_W-1:0] cnt_q;
	logic [BLINK_W-1:0] cnt_dec;
	logic [BLINK_W-1:0] cnt_nxt;
	logic               lamp_q;
	logic               lamp_nxt;
	logic               cancel_lamp_q;
	logic               req_q;
	logic               req_nxt;
	status_t            status_q;
	status_t            status_nxt;
	logic               req_set;
	logic               coop_go;
	logic               entry;
	logic               moving;
	logic               leaving;

	assign cnt_dec = (ms_tick && cnt_q != '0) ? cnt_q - BLINK_W'(1) : cnt_q;
	assign req_set = req_q | (mi.cancel_btn & mi.push_btn);
	assign coop_go = mi.coop & req_set;
	assign entry   = mi.relay & ~mi.clear;
	assign moving  = mi.relay & mi.clear;
	assign leaving = ~mi.relay & mi.clear;
	assign reload  = ((phase_q == PH_CLEAR) && coop_go)
		|| ((phase_q == PH_ON_LINE) && moving && coop_go);

	assign nxt = '{lamp: lamp_nxt, status: status_nxt, phase: phase_nxt};

	// next state, cancel wins over entry
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_BLINK: begin
				if (!win_live && !mi.relay) phase_nxt = PH_CLOSED;
			end
			PH_CLOSED: begin
				if (moving) phase_nxt = PH_CLEAR;
			end
			PH_CLEAR: begin
				if (coop_go) phase_nxt = PH_BLINK;
				else if (entry) phase_nxt = PH_ON_LINE;
			end
			PH_ON_LINE: begin
				if (moving) begin
					if (coop_go) phase_nxt = PH_BLINK;
				end else if (leaving) begin
					phase_nxt = PH_EXIT;
				end
			end
			PH_EXIT: begin
				if (leaving) phase_nxt = PH_BLINK;
			end
			default: phase_nxt = phase_q;
		endcase
	end

	// outputs
	always_comb begin
		lamp_nxt        = lamp_q;
		status_nxt      = status_q;
		cancel_lamp_nxt = cancel_lamp_q;
		req_nxt         = req_q;
		cnt_nxt         = cnt_dec;
		case (phase_q)
			PH_BLINK: begin
				if (win_live) begin
					if (cnt_dec == '0) begin
						lamp_nxt        = ~lamp_q;
						cancel_lamp_nxt = ~cancel_lamp_q;
						cnt_nxt         = blink_period;
					end
				end else if (!mi.relay) begin
					lamp_nxt        = 1'b0;
					cancel_lamp_nxt = 1'b0;
				end
			end
			PH_CLOSED: begin
				if (moving) begin
					lamp_nxt   = 1'b1;
					status_nxt = STAT_LINE_CLEAR;
				end
			end
			PH_CLEAR: begin
				if (entry) lamp_nxt = 1'b0;
				req_nxt = req_set & ~coop_go;
			end
			PH_ON_LINE: begin
				if (moving) begin
					if (cnt_dec == '0) begin
						lamp_nxt = ~lamp_q;
						cnt_nxt  = blink_period;
					end
					req_nxt    = req_set & ~coop_go;
					status_nxt = STAT_TRAIN_MOVING;
				end
			end
			PH_EXIT: begin
				if (leaving) begin
					lamp_nxt   = 1'b0;
					status_nxt = STAT_TRAIN_EXIT;
				end
			end
			default: lamp_nxt = lamp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_BLINK;
			cnt_q         <= '0;
			lamp_q        <= 1'b0;
			cancel_lamp_q <= 1'b0;
			req_q         <= 1'b0;
			status_q      <= STAT_NONE;
		end else if (step) begin
			phase_q       <= phase_nxt;
			cnt_q         <= cnt_nxt;
			lamp_q        <= lamp_nxt;
			cancel_lamp_q <= cancel_lamp_nxt;
			req_q         <= req_nxt;
			status_q      <= status_nxt;
		end
	end

endmodule
